>>> rtl/core/i2a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared widths, format codes, emitter states and the digit-to-ASCII helper
// for the integer to ASCII converter.
// ----------------------------------------------------------------------------
package i2a_pkg;

  // Width of the number that is converted (bits above it are ignored)
  localparam int VALUE_BITS = 32;
  // Width of the value field on the input channel
  localparam int VALUE_W    = 32;
  localparam int TYPE_W     = 3;
  localparam int CHAR_W     = 7;

  // Digit counts per radix
  localparam int DEC_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int BIN_DIGITS = VALUE_BITS;
  localparam int BCD_W      = 4 * DEC_DIGITS;

  // Digit shift register: the BCD image is always the widest layout
  localparam int SREG_W     = BCD_W;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int BIT_IDX_W  = $clog2(VALUE_BITS);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

  typedef logic [VALUE_BITS-1:0] mag_t;
  typedef logic [BCD_W-1:0]      bcd_t;
  typedef logic [SREG_W-1:0]     sreg_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // Request codes on req_type
  typedef enum logic [TYPE_W-1:0] {
    FMT_UDEC = 3'd0,
    FMT_SDEC = 3'd1,
    FMT_HEX  = 3'd2,
    FMT_OCT  = 3'd3,
    FMT_BIN  = 3'd4
  } fmt_t;

  // Digit layout held by the emitter
  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_HEX,
    RADIX_OCT,
    RADIX_BIN
  } radix_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SKIP,
    EM_SIGN,
    EM_DIGIT
  } emit_state_t;

  // Load command from the front end into the emitter
  typedef struct packed {
    logic   valid;
    radix_t radix;
    logic   sign;
    cnt_t   count;
    sreg_t  digits;
  } emit_load_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_A + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

>>> rtl/core/i2a_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_if
// Valid/ready channels: number requests in, ASCII characters out.
// ----------------------------------------------------------------------------
interface i2a_in_if;
  logic                         valid;
  logic                         ready;
  logic [i2a_pkg::VALUE_W-1:0]  value;
  logic [i2a_pkg::TYPE_W-1:0]   req_type;

  modport source (output valid, value, req_type, input ready);
  modport sink   (input valid, value, req_type, output ready);
endinterface

interface i2a_out_if;
  logic                         valid;
  logic                         ready;
  logic [i2a_pkg::CHAR_W-1:0]   ascii_char;
  logic                         last_char;

  modport source (output valid, ascii_char, last_char, input ready);
  modport sink   (input valid, ascii_char, last_char, output ready);
endinterface

>>> rtl/core/i2a_dabble.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_dabble
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit
// per cycle.
// ----------------------------------------------------------------------------
module i2a_dabble (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  i2a_pkg::mag_t      start_value,
  output logic               busy,
  output logic               done,
  output i2a_pkg::bcd_t      bcd_result
);

  i2a_pkg::mag_t                    mag;
  i2a_pkg::bcd_t                    bcd;
  i2a_pkg::bcd_t                    bcd_adj;
  i2a_pkg::bcd_t                    bcd_next;
  logic [i2a_pkg::BIT_IDX_W-1:0]    bit_idx;

  // Add 3 to every BCD digit of 5 or more, then shift in the next bit
  always_comb begin
    for (int i = 0; i < i2a_pkg::DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3
                                                   : bcd[4*i +: 4];
    end
    bcd_next = {bcd_adj[i2a_pkg::BCD_W-2:0], mag[i2a_pkg::VALUE_BITS-1]};
  end

  assign done       = busy && (bit_idx == i2a_pkg::BIT_IDX_W'(i2a_pkg::VALUE_BITS - 1));
  assign bcd_result = bcd_next;

  // Control: run from start until the last magnitude bit is shifted in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_idx <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      bit_idx <= '0;
    end else if (busy) begin
      bit_idx <= bit_idx + 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: advance magnitude and BCD accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      mag <= start_value;
      bcd <= '0;
    end else if (busy) begin
      mag <= mag << 1;
      bcd <= bcd_next;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("dabble started while busy");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("dabble still busy after done");

endmodule

>>> rtl/core/i2a_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_emit
// Digit shift register and character emitter: drops leading zeros, sends an
// optional '-' and then one digit per transfer, most significant first.
// ----------------------------------------------------------------------------
module i2a_emit (
  input  logic                    clk,
  input  logic                    rst,
  input  i2a_pkg::emit_load_t     load,
  output logic                    busy,
  i2a_out_if.source               char_out
);

  i2a_pkg::emit_state_t           state;
  i2a_pkg::emit_state_t           state_next;
  i2a_pkg::sreg_t                 sreg;
  i2a_pkg::sreg_t                 sreg_shifted;
  i2a_pkg::cnt_t                  count;
  i2a_pkg::radix_t                radix;
  logic                           sign_hold;

  logic [3:0]                     top_digit;
  logic                           slot_free;
  logic                           skip_zero;
  logic                           shift_en;
  logic                           put_char;
  logic [i2a_pkg::CHAR_W-1:0]     char_val;
  logic                           last_val;

  assign busy      = (state != i2a_pkg::EM_IDLE);
  assign slot_free = !char_out.valid || char_out.ready;

  // Pick the top digit and the shifted register for the current radix
  always_comb begin
    case (radix)
      i2a_pkg::RADIX_OCT: begin
        top_digit    = {1'b0, sreg[i2a_pkg::SREG_W-1 -: 3]};
        sreg_shifted = sreg << 3;
      end
      i2a_pkg::RADIX_BIN: begin
        top_digit    = {3'b000, sreg[i2a_pkg::SREG_W-1]};
        sreg_shifted = sreg << 1;
      end
      default: begin
        top_digit    = sreg[i2a_pkg::SREG_W-1 -: 4];
        sreg_shifted = sreg << 4;
      end
    endcase
  end

  assign skip_zero = (count > i2a_pkg::CNT_W'(1)) && (top_digit == 4'd0);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      i2a_pkg::EM_IDLE: begin
        if (load.valid) begin
          state_next = i2a_pkg::EM_SKIP;
        end
      end
      i2a_pkg::EM_SKIP: begin
        if (!skip_zero) begin
          state_next = sign_hold ? i2a_pkg::EM_SIGN : i2a_pkg::EM_DIGIT;
        end
      end
      i2a_pkg::EM_SIGN: begin
        if (slot_free) begin
          state_next = i2a_pkg::EM_DIGIT;
        end
      end
      i2a_pkg::EM_DIGIT: begin
        if (slot_free && (count == i2a_pkg::CNT_W'(1))) begin
          state_next = i2a_pkg::EM_IDLE;
        end
      end
      default: state_next = i2a_pkg::EM_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    shift_en = 1'b0;
    put_char = 1'b0;
    char_val = i2a_pkg::ASCII_ZERO;
    last_val = 1'b0;
    case (state)
      i2a_pkg::EM_SKIP: begin
        shift_en = skip_zero;
      end
      i2a_pkg::EM_SIGN: begin
        put_char = slot_free;
        char_val = i2a_pkg::ASCII_MINUS;
      end
      i2a_pkg::EM_DIGIT: begin
        put_char = slot_free;
        shift_en = slot_free;
        char_val = i2a_pkg::digit_to_ascii(top_digit);
        last_val = (count == i2a_pkg::CNT_W'(1));
      end
      default: begin
        shift_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2a_pkg::EM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Digit register: load a new number or advance one digit
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sign_hold <= 1'b0;
    end else if (load.valid && !busy) begin
      count     <= load.count;
      sign_hold <= load.sign;
    end else begin
      if (shift_en) begin
        count <= count - 1'b1;
      end
      if (put_char && (state == i2a_pkg::EM_SIGN)) begin
        sign_hold <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid && !busy) begin
      sreg  <= load.digits;
      radix <= load.radix;
    end else if (shift_en) begin
      sreg  <= sreg_shifted;
    end
  end

  // Output register: hold a character until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      char_out.valid <= 1'b0;
    end else if (put_char) begin
      char_out.valid <= 1'b1;
    end else if (char_out.ready) begin
      char_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_char) begin
      char_out.ascii_char <= char_val;
      char_out.last_char  <= last_val;
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    load.valid |-> !busy)
    else $error("emitter loaded while busy");

  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    (state == i2a_pkg::EM_DIGIT) |-> (count != '0))
    else $error("emitting a digit with none left");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (put_char && last_val) |=> (state == i2a_pkg::EM_IDLE))
    else $error("emitter busy after last character");

endmodule

>>> rtl/core/integer_to_ascii_radix_top.sv
`timescale 1ns / 1ps
// Converts one number per request into ASCII characters, most significant
// first, with last_char on the final one. A request is taken only while the
// converter is idle. Hex, octal and binary go straight to the digit shift
// register; decimal first runs through the bit-serial BCD converter. The
// emitter then drops one leading zero digit per cycle and sends one
// character per cycle while the output is taken.
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_top
// Request decode, sign handling and alignment of digits into the emitter.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_top (
  input  logic          clk,
  input  logic          rst,
  i2a_in_if.sink        num_in,
  i2a_out_if.source     char_out
);

  logic                       accept;
  logic                       is_dec;
  logic                       neg;
  i2a_pkg::mag_t              raw;
  i2a_pkg::mag_t              magnitude;
  i2a_pkg::fmt_t              fmt;
  logic                       sign_pending;

  logic                       dab_start;
  logic                       dab_busy;
  logic                       dab_done;
  i2a_pkg::bcd_t              dab_bcd;

  i2a_pkg::emit_load_t        load;
  logic                       emit_busy;

  assign num_in.ready = !dab_busy && !emit_busy;
  assign accept       = num_in.valid && num_in.ready;

  // Decode request; unknown codes fall back to unsigned decimal
  always_comb begin
    case (num_in.req_type)
      i2a_pkg::FMT_SDEC: fmt = i2a_pkg::FMT_SDEC;
      i2a_pkg::FMT_HEX:  fmt = i2a_pkg::FMT_HEX;
      i2a_pkg::FMT_OCT:  fmt = i2a_pkg::FMT_OCT;
      i2a_pkg::FMT_BIN:  fmt = i2a_pkg::FMT_BIN;
      default:           fmt = i2a_pkg::FMT_UDEC;
    endcase
    raw       = i2a_pkg::mag_t'(num_in.value);
    neg       = (fmt == i2a_pkg::FMT_SDEC) && raw[i2a_pkg::VALUE_BITS-1];
    magnitude = neg ? (~raw + 1'b1) : raw;
    is_dec    = (fmt == i2a_pkg::FMT_UDEC) || (fmt == i2a_pkg::FMT_SDEC);
  end

  assign dab_start = accept && is_dec;

  // Hold the sign while the decimal conversion runs
  always_ff @(posedge clk) begin
    if (rst) begin
      sign_pending <= 1'b0;
    end else if (accept) begin
      sign_pending <= neg;
    end
  end

  // Build the emitter load: power-of-two radices at accept, decimal at done
  always_comb begin
    load.valid  = 1'b0;
    load.radix  = i2a_pkg::RADIX_DEC;
    load.sign   = 1'b0;
    load.count  = i2a_pkg::CNT_W'(i2a_pkg::DEC_DIGITS);
    load.digits = i2a_pkg::sreg_t'(dab_bcd) << (i2a_pkg::SREG_W - i2a_pkg::BCD_W);
    if (dab_done) begin
      load.valid = 1'b1;
      load.sign  = sign_pending;
    end else if (accept && !is_dec) begin
      load.valid = 1'b1;
      case (fmt)
        i2a_pkg::FMT_HEX: begin
          load.radix  = i2a_pkg::RADIX_HEX;
          load.count  = i2a_pkg::CNT_W'(i2a_pkg::HEX_DIGITS);
          load.digits = i2a_pkg::sreg_t'(magnitude)
                        << (i2a_pkg::SREG_W - 4 * i2a_pkg::HEX_DIGITS);
        end
        i2a_pkg::FMT_OCT: begin
          load.radix  = i2a_pkg::RADIX_OCT;
          load.count  = i2a_pkg::CNT_W'(i2a_pkg::OCT_DIGITS);
          load.digits = i2a_pkg::sreg_t'(magnitude)
                        << (i2a_pkg::SREG_W - 3 * i2a_pkg::OCT_DIGITS);
        end
        default: begin
          load.radix  = i2a_pkg::RADIX_BIN;
          load.count  = i2a_pkg::CNT_W'(i2a_pkg::BIN_DIGITS);
          load.digits = i2a_pkg::sreg_t'(magnitude)
                        << (i2a_pkg::SREG_W - i2a_pkg::BIN_DIGITS);
        end
      endcase
    end
  end

  i2a_dabble u_dabble (
    .clk         (clk),
    .rst         (rst),
    .start       (dab_start),
    .start_value (magnitude),
    .busy        (dab_busy),
    .done        (dab_done),
    .bcd_result  (dab_bcd)
  );

  i2a_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .busy     (emit_busy),
    .char_out (char_out)
  );

  a_one_engine: assert property (@(posedge clk) disable iff (rst)
    !(dab_busy && emit_busy))
    else $error("converter and emitter active together");

endmodule

>>> tb/sv/tb_integer_to_ascii_radix_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix_top
// Self-checking bench for the integer to ASCII converter. A short directed
// list and a randomized stream of numbers in every format are pushed through
// the request channel. A scoreboard predicts the characters of each accepted
// number and checks every character transfer, in order, with random gaps on
// both sides and two long output stalls.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_radix_top;
  import i2a_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last_flag;
  } char_item_t;

  // Predicts the characters of each number and checks the output stream
  class ascii_char_board;
    char_item_t expected_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    // Queue the characters that one accepted number should produce
    function void add_number(logic [VALUE_W-1:0] value, logic [TYPE_W-1:0] code);
      mag_t        mag;
      logic [3:0]  digits[$];
      logic [3:0]  d;
      int unsigned shift;
      logic        neg;
      char_item_t  item;
      mag = mag_t'(value);
      neg = (code == FMT_SDEC) && mag[VALUE_BITS-1];
      if (neg) begin
        mag = -mag;
      end
      case (code)
        FMT_HEX: shift = 4;
        FMT_OCT: shift = 3;
        FMT_BIN: shift = 1;
        default: shift = 0;
      endcase
      // Extract digits, least significant first, storing most significant first
      if (mag == '0) begin
        digits.push_front(4'd0);
      end
      while (mag != '0) begin
        if (shift != 0) begin
          d   = 4'(mag & mag_t'((1 << shift) - 1));
          mag = mag >> shift;
        end else begin
          d   = 4'(mag % 10);
          mag = mag / 10;
        end
        digits.push_front(d);
      end
      if (neg) begin
        item.ch        = ASCII_MINUS;
        item.last_flag = 1'b0;
        expected_chars.push_back(item);
      end
      foreach (digits[i]) begin
        if (digits[i] < 4'd10) begin
          item.ch = ASCII_ZERO + CHAR_W'(digits[i]);
        end else begin
          item.ch = ASCII_A + CHAR_W'(digits[i] - 4'd10);
        end
        item.last_flag = (i == digits.size() - 1);
        expected_chars.push_back(item);
      end
    endfunction

    // Compare one output transfer with the oldest expected character
    function void check_char(logic [CHAR_W-1:0] ch, logic last_flag);
      char_item_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual char %h last %b",
                 $time, ch, last_flag);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (want.ch !== ch) begin
        $display("%0t: ascii_char mismatch: expected %h, actual %h",
                 $time, want.ch, ch);
        errors++;
      end
      if (want.last_flag !== last_flag) begin
        $display("%0t: last_char mismatch: expected %b, actual %b",
                 $time, want.last_flag, last_flag);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic steady = 1'b0;

  i2a_in_if  num_in ();
  i2a_out_if char_out ();

  ascii_char_board board = new();

  integer_to_ascii_radix_top uut (
    .clk      (clk),
    .rst      (rst),
    .num_in   (num_in),
    .char_out (char_out)
  );

  always #5 clk = ~clk;

  // Idle length: mostly none or short, a few long; none in steady stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(30, 80);
  endfunction

  // Offer one number and hold it until the request transfer
  task automatic send_number(input logic [VALUE_W-1:0] value,
                             input logic [TYPE_W-1:0] code);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      num_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    num_in.valid    <= 1'b1;
    num_in.value    <= value;
    num_in.req_type <= code;
    do @(posedge clk); while (!num_in.ready);
    board.add_number(value, code);
  endtask

  // Random value: wide, small, powers of two or one below, and small negatives
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 20);
      3:       return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
      4:       return -$urandom_range(1, 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TYPE_W-1:0] pick_code();
    if ($urandom_range(0, 9) < 9) begin
      return TYPE_W'($urandom_range(FMT_UDEC, FMT_BIN));
    end
    return TYPE_W'($urandom_range(5, 7));
  endfunction

  // Receive characters, with random stalls and two long hold-offs
  initial begin
    int stall;
    int chars_taken;
    chars_taken = 0;
    char_out.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = pick_gap();
      if (chars_taken == 50 || chars_taken == 500) begin
        stall = 300;
      end
      if (stall > 0) begin
        char_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      char_out.ready <= 1'b1;
      do @(posedge clk); while (!char_out.valid);
      board.check_char(char_out.ascii_char, char_out.last_char);
      chars_taken++;
    end
  end

  // Stimulus
  initial begin
    int drain;
    rst             <= 1'b1;
    num_in.valid    <= 1'b0;
    num_in.value    <= '0;
    num_in.req_type <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero in every code, all ones in every format, sign edges, digit ranges
    for (int c = 0; c < 8; c++) begin
      send_number('0, TYPE_W'(c));
    end
    send_number(32'hFFFF_FFFF, FMT_UDEC);
    send_number(32'hFFFF_FFFF, FMT_SDEC);
    send_number(32'hFFFF_FFFF, FMT_HEX);
    send_number(32'hFFFF_FFFF, FMT_OCT);
    send_number(32'hFFFF_FFFF, FMT_BIN);
    send_number(32'hFFFF_FFFF, TYPE_W'(7));
    send_number(32'h8000_0000, FMT_SDEC);
    send_number(32'h8000_0000, FMT_UDEC);
    send_number(32'h7FFF_FFFF, FMT_SDEC);
    send_number(32'd1, FMT_BIN);
    send_number(32'hFEDC_BA98, FMT_HEX);
    send_number(32'o12345670, FMT_OCT);
    send_number(32'd1000000000, FMT_UDEC);
    send_number(32'd999999999, FMT_UDEC);
    send_number(32'd12345, TYPE_W'(5));
    send_number(32'hDEAD_BEEF, TYPE_W'(6));

    // Random stream, with one stretch of back-to-back traffic
    for (int n = 0; n < 126; n++) begin
      steady <= (n >= 50 && n < 90);
      send_number(pick_value(), pick_code());
    end
    num_in.valid <= 1'b0;

    // Drain outstanding characters, then watch for strays
    drain = 0;
    while (board.pending() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (100) @(posedge clk);
    if (board.pending() != 0) begin
      $display("%0t: %0d characters never arrived: expected %0d more, actual 0",
               $time, board.pending(), board.pending());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
